FILE: rtl/all_pairs_shortest_path_assert.svh
// Assertion macros shared by the shortest-path block.
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APSP_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/apsp_pkg.sv
// Shared types and constants of the shortest-path block.
package apsp_pkg;

    // Field widths of the command and result transactions.
    localparam int CMD_W      = 2;
    localparam int NODE_W     = 8;
    localparam int WEIGHT_W   = 32;
    localparam int COUNT_W    = 9;
    localparam int OUT_DIST_W = 48;
    localparam int WIDE_W     = 64;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_QUERY = 2'd3
    } apsp_cmd_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_RD,
        ST_ADD_WR_AB,
        ST_ADD_WR_BA,
        ST_QRY_RD,
        ST_QRY_OUT,
        ST_SLV_DIK,
        ST_SLV_LD,
        ST_SLV_RD,
        ST_SLV_UPD
    } apsp_state_t;

endpackage

FILE: rtl/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest-path engine.
// The block keeps a distance matrix in one RAM and runs one command per
// transaction: clear, add edge, solve (Floyd-Warshall) and query. A single
// saturating adder and comparator, stepped by a small sequencer, does all the
// relaxation work, and the block stalls its command channel until a command is
// finished. Add edge reads the stored entry and writes the smaller weight in
// both directions, but writes nothing when an endpoint is out of range; query
// reads its entry and then waits for the result register, and clear sweeps the
// whole RAM at one entry a cycle. In solve, each relaxation step reads two
// entries and then adds, compares and writes back, and each row first
// fetches its distance to the intermediate node. The matrix holds no
// defined contents until the first clear. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
`include "all_pairs_shortest_path_assert.svh"

module all_pairs_shortest_path
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int DIST_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Command channel.
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [NODE_W-1:0]     node_a,
    input  logic [NODE_W-1:0]     node_b,
    input  logic [WEIGHT_W-1:0]   weight,
    // Result channel.
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  reachable,
    output logic [OUT_DIST_W-1:0] distance,
    // Configuration channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int AW    = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;
    localparam int NU_W  = $clog2(MAX_NODES + 1);
    localparam int CW    = (NU_W > COUNT_W) ? NU_W : COUNT_W;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    apsp_state_t state_reg;
    apsp_state_t state_next;

    logic [COUNT_W-1:0]   node_count_reg;
    logic [IDX_W-1:0]     cmd_a_reg;
    logic [IDX_W-1:0]     cmd_b_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic                 in_range_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [IDX_W-1:0]     i_reg;
    logic [IDX_W-1:0]     j_reg;
    logic [DIST_BITS-1:0] dik_reg;
    logic [DIST_BITS-1:0] min_reg;

    logic                  res_valid_reg;
    logic                  reachable_reg;
    logic [OUT_DIST_W-1:0] distance_reg;

    logic                 cmd_fire;
    logic                 out_free;
    logic [CW-1:0]        count_ext;
    logic [CW-1:0]        n_use;
    logic [CW-1:0]        n_last;
    logic                 last_j;
    logic                 last_i;
    logic                 last_k;
    logic                 clr_last;
    logic                 clr_diag;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DIST_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [DIST_BITS-1:0] rd_data_a;
    logic [DIST_BITS-1:0] rd_data_b;

    logic [DIST_BITS:0]   via_sum;
    logic [DIST_BITS-1:0] via;
    logic                 relax;
    logic [DIST_BITS-1:0] w_ext;
    logic [DIST_BITS-1:0] add_min;
    logic [DIST_BITS-1:0] q_dist_raw;
    logic [WIDE_W-1:0]    q_wide;
    logic                 q_reach;
    logic [OUT_DIST_W-1:0] q_dist;

    // Matrix storage.
    apsp_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_matrix (
        .clk       (clk),
        .we        (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .re        (mem_re),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Handshake helpers and the number of nodes in use.
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign count_ext = CW'(node_count_reg);
    assign n_use     = (count_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : count_ext;
    assign n_last    = n_use - CW'(1);
    assign last_j    = (CW'(j_reg) == n_last);
    assign last_i    = (CW'(i_reg) == n_last);
    assign last_k    = (CW'(k_reg) == n_last);
    assign clr_last  = &clr_addr_reg;
    assign clr_diag  = (clr_addr_reg[AW-1:IDX_W] == clr_addr_reg[IDX_W-1:0]);

    // Shared saturating adder and comparator for relaxation.
    // Stored distances are unsigned and never exceed infinity, so the distance to the
    // intermediate node cannot shrink during its own row and needs no reload.
    assign via_sum = {1'b0, dik_reg} + {1'b0, rd_data_a};
    assign via     = (dik_reg == DIST_INF || rd_data_a == DIST_INF ||
                      via_sum >= {1'b0, DIST_INF}) ? DIST_INF : via_sum[DIST_BITS-1:0];
    assign relax   = (via < rd_data_b);

    // Minimum of the stored and new edge weight.
    assign w_ext   = DIST_BITS'(weight_reg);
    assign add_min = (w_ext < rd_data_a) ? w_ext : rd_data_a;

    // Query answer formatting.
    assign q_dist_raw = in_range_reg ? rd_data_a : DIST_INF;
    assign q_reach    = (q_dist_raw != DIST_INF);
    assign q_wide     = WIDE_W'(q_dist_raw);
    assign q_dist     = q_reach ? q_wide[OUT_DIST_W-1:0] : '0;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (apsp_cmd_t'(command))
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_ADD:   state_next = ST_ADD_RD;
                        CMD_SOLVE: state_next = (n_use == '0) ? ST_IDLE : ST_SLV_DIK;
                        CMD_QUERY: state_next = ST_QRY_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:     state_next = clr_last ? ST_IDLE : ST_CLEAR;
            ST_ADD_RD:    state_next = ST_ADD_WR_AB;
            ST_ADD_WR_AB: state_next = in_range_reg ? ST_ADD_WR_BA : ST_IDLE;
            ST_ADD_WR_BA: state_next = ST_IDLE;
            ST_QRY_RD:    state_next = ST_QRY_OUT;
            ST_QRY_OUT:   state_next = out_free ? ST_IDLE : ST_QRY_OUT;
            ST_SLV_DIK:   state_next = ST_SLV_LD;
            ST_SLV_LD:    state_next = ST_SLV_UPD;
            ST_SLV_RD:    state_next = ST_SLV_UPD;
            ST_SLV_UPD:
            begin
                if (!last_j)
                begin
                    state_next = ST_SLV_RD;
                end
                else if (!(last_i && last_k))
                begin
                    state_next = ST_SLV_DIK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output logic of the sequencer: stall and RAM controls.
    always_comb
    begin
        cmd_stall = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = clr_diag ? '0 : DIST_INF;
            end
            ST_ADD_RD, ST_QRY_RD:
            begin
                mem_re    = 1'b1;
                rd_addr_a = {cmd_a_reg, cmd_b_reg};
            end
            ST_ADD_WR_AB:
            begin
                mem_we    = in_range_reg;
                mem_waddr = {cmd_a_reg, cmd_b_reg};
                mem_wdata = add_min;
            end
            ST_ADD_WR_BA:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cmd_b_reg, cmd_a_reg};
                mem_wdata = min_reg;
            end
            ST_SLV_DIK:
            begin
                mem_re    = 1'b1;
                rd_addr_a = {i_reg, k_reg};
            end
            ST_SLV_LD, ST_SLV_RD:
            begin
                mem_re    = 1'b1;
                rd_addr_a = {k_reg, j_reg};
                rd_addr_b = {i_reg, j_reg};
            end
            ST_SLV_UPD:
            begin
                mem_we    = relax;
                mem_waddr = {i_reg, j_reg};
                mem_wdata = via;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // State, configuration and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= COUNT_RESET;
            clr_addr_reg   <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
            if (cmd_fire)
            begin
                clr_addr_reg <= '0;
                k_reg        <= '0;
                i_reg        <= '0;
                j_reg        <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            else if (state_reg == ST_SLV_UPD)
            begin
                if (!last_j)
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
                else
                begin
                    j_reg <= '0;
                    if (!last_i)
                    begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        i_reg <= '0;
                        k_reg <= k_reg + IDX_W'(1);
                    end
                end
            end
        end
    end

    // Command operands and intermediate distances.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_a_reg    <= IDX_W'(node_a);
            cmd_b_reg    <= IDX_W'(node_b);
            weight_reg   <= weight;
            in_range_reg <= (CW'(node_a) < n_use) && (CW'(node_b) < n_use);
        end
        if (state_reg == ST_SLV_LD)
        begin
            dik_reg <= rd_data_a;
        end
        if (state_reg == ST_ADD_WR_AB)
        begin
            min_reg <= add_min;
        end
    end

    // Result register: a query answer waits here until the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_QRY_OUT && out_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_QRY_OUT && out_free)
        begin
            reachable_reg <= q_reach;
            distance_reg  <= q_dist;
        end
    end

    assign res_valid = res_valid_reg;
    assign reachable = reachable_reg;
    assign distance  = distance_reg;
    assign cfg_ready = 1'b1;

    // The matrix is only written by the sweep, the edge update or relaxation.
    `APSP_ASSERT_HOLDS(a_write_state, clk, rst_n, mem_we, state_reg == ST_CLEAR || state_reg == ST_ADD_WR_AB || state_reg == ST_ADD_WR_BA || state_reg == ST_SLV_UPD, "matrix written outside a write state")
    // Relaxation only ever lowers a distance.
    `APSP_ASSERT_HOLDS(a_relax_lowers, clk, rst_n, state_reg == ST_SLV_UPD && mem_we, mem_wdata < rd_data_b, "relaxation raised a distance")
    // A new result comes only from a finished query.
    `APSP_ASSERT_NEXT(a_result_source, clk, rst_n, !res_valid_reg, !res_valid_reg || $past(state_reg) == ST_QRY_OUT, "result without a query")
    // Every accepted command other than solve keeps the block busy next cycle.
    `APSP_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && !cmd_stall && command != CMD_SOLVE, cmd_stall, "command accepted without leaving idle")

endmodule

FILE: rtl/apsp_ram.sv
// Generic RAM with one write port and two registered read ports.
module apsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule
